FILE: rtl/ipfl_pkg.sv
`timescale 1ns / 1ps

package ipfl_pkg;

  localparam int POOL_DEPTH = 1024;
  localparam int INDEX_W    = 10;
  localparam int COUNT_W    = 11;
  localparam int LINK_W     = 11;
  localparam int ADDR_W     = $clog2(POOL_DEPTH);

  localparam logic [LINK_W-1:0]  EMPTY_MARK = '1;
  localparam logic [COUNT_W-1:0] DEPTH_LIM  = COUNT_W'(POOL_DEPTH);

  typedef logic [1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EXHAUSTED = 2'd1;
  localparam status_t ST_INVALID   = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef struct packed {
    logic capture;
    logic exec;
  } ipfl_cmd_t;

endpackage

FILE: rtl/ipfl_if.sv
`timescale 1ns / 1ps

interface ipfl_req_if import ipfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [INDEX_W-1:0] slot_index;

  modport source (output valid, output func, output slot_index, input ready);
  modport sink   (input valid, input func, input slot_index, output ready);
endinterface

interface ipfl_rsp_if import ipfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] granted_index;
  status_t            status;
  logic [COUNT_W-1:0] slots_touched;

  modport source (output valid, output granted_index, output status, output slots_touched,
                  input ready);
  modport sink   (input valid, input granted_index, input status, input slots_touched,
                  output ready);
endinterface

interface ipfl_cfg_if import ipfl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ipfl_ram.sv
`timescale 1ns / 1ps

module ipfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/ipfl_ctrl.sv
`timescale 1ns / 1ps

module ipfl_ctrl import ipfl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ipfl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  // result register can take a new value if empty or draining this cycle
  assign out_free    = !out_valid_r || out_ready;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state_r == S_EXEC) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/ipfl_dp.sv
`timescale 1ns / 1ps

module ipfl_dp import ipfl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ipfl_cmd_t          cmd,
  input  logic               in_func,
  input  logic [INDEX_W-1:0] in_slot_index,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_data,
  output logic [INDEX_W-1:0] out_granted_index,
  output status_t            out_status,
  output logic [COUNT_W-1:0] out_slots_touched
);

  logic               func_r;
  logic [INDEX_W-1:0] idx_r;
  logic [LINK_W-1:0]  head_r, head_nxt;
  logic [COUNT_W-1:0] bump_r, bump_nxt;
  logic [COUNT_W-1:0] pool_slots_r;
  logic [COUNT_W-1:0] lim;
  logic [LINK_W-1:0]  link_rdata;
  logic               link_we;
  logic [INDEX_W-1:0] granted;
  status_t            status;
  logic [COUNT_W-1:0] touched;
  logic [INDEX_W-1:0] granted_r;
  status_t            status_r;
  logic [COUNT_W-1:0] touched_r;

  ipfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_DEPTH)
  ) u_links (
    .clk   (clk),
    .we    (link_we),
    .waddr (ADDR_W'(idx_r)),
    .wdata (head_r),
    .re    (cmd.capture),
    .raddr (head_r[ADDR_W-1:0]),
    .rdata (link_rdata)
  );

  assign lim = (pool_slots_r > DEPTH_LIM) ? DEPTH_LIM : pool_slots_r;

  always_comb begin
    head_nxt = head_r;
    bump_nxt = bump_r;
    granted  = '0;
    status   = ST_OK;
    link_we  = 1'b0;
    if (func_r == FUNC_ALLOC) begin
      // pop the free list first, then fall back to never-used slots
      priority if (head_r != EMPTY_MARK && head_r < DEPTH_LIM) begin
        granted  = head_r[INDEX_W-1:0];
        head_nxt = link_rdata;
      end else if (bump_r < lim) begin
        granted  = bump_r[INDEX_W-1:0];
        bump_nxt = bump_r + COUNT_W'(1);
      end else begin
        status = ST_EXHAUSTED;
      end
    end else begin
      if (COUNT_W'(idx_r) < bump_r && COUNT_W'(idx_r) < DEPTH_LIM) begin
        link_we  = cmd.exec;
        head_nxt = LINK_W'(idx_r);
      end else begin
        status = ST_INVALID;
      end
    end
    touched = (bump_nxt < lim) ? bump_nxt : lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= EMPTY_MARK;
      bump_r       <= '0;
      pool_slots_r <= '0;
    end else begin
      if (cmd.exec) begin
        head_r <= head_nxt;
        bump_r <= bump_nxt;
      end
      if (cfg_we) begin
        pool_slots_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      idx_r  <= in_slot_index;
    end
    if (cmd.exec) begin
      granted_r <= granted;
      status_r  <= status;
      touched_r <= touched;
    end
  end

  assign out_granted_index = granted_r;
  assign out_status        = status_r;
  assign out_slots_touched = touched_r;

endmodule

FILE: rtl/index_pool_free_list_allocator.sv
`timescale 1ns / 1ps
// Slot index pool allocator: free list with a bump counter behind it.
// in_ch carries one operation per transfer: func 0 allocates a slot,
// func 1 frees slot_index. out_ch returns exactly one result per
// operation, in order: granted_index, status (ok, exhausted, invalid
// index) and slots_touched. cfg_ch writes pool_slots, the active pool
// size; write it only while no operation is in flight.
// Each operation has two steps: the transfer cycle reads the link of the
// current free-list head from the synchronous link memory, and the commit
// step, which waits until the result register is free, writes the new head
// or bump count and loads the result register. A new operation is accepted
// only once the previous one has committed; its result appears on out_ch in
// the cycle after the commit.
// The result register decouples the channels: while a result waits on a
// stalled receiver, the next operation is still accepted, and it then
// holds in its commit cycle until the result register drains.
// Reset empties the free list, clears the bump count and pool_slots and
// drops out_ch.valid; the link memory is not cleared and needs no pass.
module index_pool_free_list_allocator import ipfl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ipfl_req_if.sink   in_ch,
  ipfl_rsp_if.source out_ch,
  ipfl_cfg_if.sink   cfg_ch
);

  ipfl_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  ipfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ipfl_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_func           (in_ch.func),
    .in_slot_index     (in_ch.slot_index),
    .cfg_we            (cfg_ch.valid),
    .cfg_data          (cfg_ch.data),
    .out_granted_index (out_ch.granted_index),
    .out_status        (out_ch.status),
    .out_slots_touched (out_ch.slots_touched)
  );

endmodule

FILE: rtl/ipfl_checker.sv
`timescale 1ns / 1ps

module ipfl_checker import ipfl_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [INDEX_W-1:0] granted_index,
  input status_t            status
);

  // one operation in flight: ready drops right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_OK || status == ST_EXHAUSTED || status == ST_INVALID))
    else $error("illegal status code");

  a_grant_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != ST_OK) |-> (granted_index == '0))
    else $error("nonzero index with error status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind index_pool_free_list_allocator ipfl_checker u_ipfl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .granted_index (out_ch.granted_index),
  .status        (out_ch.status)
);

FILE: verif/pool_checker.sv
`timescale 1ns / 1ps

module pool_checker import ipfl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ipfl_req_if  req_mon,
  ipfl_rsp_if  rsp_mon,
  ipfl_cfg_if  cfg_mon,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic [INDEX_W-1:0] granted_index;
    status_t            status;
    logic [COUNT_W-1:0] slots_touched;
  } pool_reply_t;

  localparam logic [COUNT_W-1:0] INDEX_SPAN = COUNT_W'(1) << INDEX_W;

  logic [LINK_W-1:0]  next_free [POOL_DEPTH];
  logic [LINK_W-1:0]  head_slot;
  logic [COUNT_W-1:0] bump_slots;
  logic [COUNT_W-1:0] pool_size;
  pool_reply_t        expected_replies [$];
  int                 mismatches;

  function automatic void note_failure(string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] pool_checker: %s", $time, what);
    end
  endfunction

  // updates the mirrored pool state and returns the reply the block owes
  function automatic pool_reply_t apply_pool_op(logic func, logic [INDEX_W-1:0] slot);
    pool_reply_t        r;
    logic [COUNT_W-1:0] lim;
    r = '0;
    r.status = ST_OK;
    lim = (pool_size > DEPTH_LIM) ? DEPTH_LIM : pool_size;
    if (lim > INDEX_SPAN) begin
      lim = INDEX_SPAN;
    end
    if (func == FUNC_ALLOC) begin
      if (head_slot != EMPTY_MARK && head_slot < DEPTH_LIM) begin
        r.granted_index = head_slot[INDEX_W-1:0];
        head_slot = next_free[head_slot[ADDR_W-1:0]];
      end else if (bump_slots < lim) begin
        r.granted_index = bump_slots[INDEX_W-1:0];
        bump_slots = bump_slots + COUNT_W'(1);
      end else begin
        r.status = ST_EXHAUSTED;
      end
    end else if (COUNT_W'(slot) < bump_slots && COUNT_W'(slot) < DEPTH_LIM) begin
      next_free[slot] = head_slot;
      head_slot = LINK_W'(slot);
    end else begin
      r.status = ST_INVALID;
    end
    r.slots_touched = (bump_slots < lim) ? bump_slots : lim;
    return r;
  endfunction

  always @(posedge clk) begin
    pool_reply_t want;
    if (!rst_n) begin
      head_slot = EMPTY_MARK;
      bump_slots = '0;
      pool_size = '0;
      expected_replies.delete();
      mismatches = 0;
    end else begin
      // result first: a reply can never belong to an operation taken at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_replies.size() == 0) begin
          note_failure($sformatf("unexpected result index %0d status %0d touched %0d",
                                 rsp_mon.granted_index, rsp_mon.status,
                                 rsp_mon.slots_touched));
        end else begin
          want = expected_replies.pop_front();
          if (rsp_mon.granted_index !== want.granted_index) begin
            note_failure($sformatf("granted_index expected %0d got %0d",
                                   want.granted_index, rsp_mon.granted_index));
          end
          if (rsp_mon.status !== want.status) begin
            note_failure($sformatf("status expected %0d got %0d",
                                   want.status, rsp_mon.status));
          end
          if (rsp_mon.slots_touched !== want.slots_touched) begin
            note_failure($sformatf("slots_touched expected %0d got %0d",
                                   want.slots_touched, rsp_mon.slots_touched));
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        pool_size = cfg_mon.data;
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_replies.push_back(apply_pool_op(req_mon.func, req_mon.slot_index));
      end
    end
    outstanding <= expected_replies.size();
    fail_count  <= mismatches;
  end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ipfl_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 110;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;

  ipfl_req_if req_ch ();
  ipfl_rsp_if rsp_ch ();
  ipfl_cfg_if cfg_ch ();

  index_pool_free_list_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch),
    .cfg_ch (cfg_ch)
  );

  pool_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .cfg_mon     (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  int   held_slots [$];   // granted and not yet given back
  logic sent_funcs [$];
  int   alloc_count;      // allocates sent so far, an upper bound on the bump count
  int   tx_stall_pct;
  int   rx_stall_pct;
  bit   hold_outputs;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  task automatic send_op(logic func, logic [INDEX_W-1:0] slot);
    int k;
    if (func == FUNC_FREE) begin
      for (k = 0; k < held_slots.size(); k++) begin
        if (held_slots[k] == slot) begin
          held_slots.delete(k);
          break;
        end
      end
    end else begin
      alloc_count++;
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.slot_index <= slot;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (tx_stall_pct > 0 && $urandom_range(0, 99) < tx_stall_pct) begin
      req_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic drain_pool_ops();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_pool_size(logic [COUNT_W-1:0] slots);
    drain_pool_ops();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= slots;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stimulus feedback only: remember which slots the pool handed out
  always @(posedge clk) begin
    if (rsp_ch.valid && rsp_ch.ready && sent_funcs.size() > 0) begin
      if (sent_funcs.pop_front() == FUNC_ALLOC && rsp_ch.status == ST_OK) begin
        held_slots.push_back(int'(rsp_ch.granted_index));
      end
    end
    if (req_ch.valid && req_ch.ready) begin
      sent_funcs.push_back(req_ch.func);
    end
  end

  initial begin : receiver
    int stall;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_outputs) begin
        hold_outputs = 1'b0;
        stall = 400;
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < rx_stall_pct) begin
          stall = pick_gap();
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int   phase_slots [PHASES];
    int   p;
    int   n;
    int   roll;
    int   alloc_pct;
    int   victim;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= FUNC_ALLOC;
    req_ch.slot_index <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.data       <= '0;
    rst_n             <= 1'b0;
    alloc_count  = 0;
    hold_outputs = 1'b0;
    tx_stall_pct = 20;
    rx_stall_pct = 20;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pool size zero out of reset: nothing to hand out or take back
    send_op(FUNC_ALLOC, '0);
    send_op(FUNC_FREE, '0);
    send_op(FUNC_FREE, '1);
    write_pool_size(COUNT_W'(3));
    send_op(FUNC_ALLOC, '1);
    send_op(FUNC_ALLOC, '0);
    send_op(FUNC_ALLOC, '0);
    send_op(FUNC_ALLOC, '0);
    send_op(FUNC_FREE, INDEX_W'(3));    // equal to bump count
    drain_pool_ops();
    send_op(FUNC_FREE, INDEX_W'(2));
    send_op(FUNC_FREE, INDEX_W'(0));
    send_op(FUNC_ALLOC, '0);
    send_op(FUNC_ALLOC, '0);
    send_op(FUNC_ALLOC, '0);  // list empty and bump at limit
    // shrink below the bump count: touched clamps, listed slots still served
    write_pool_size(COUNT_W'(1));
    send_op(FUNC_FREE, INDEX_W'(1));
    send_op(FUNC_ALLOC, '0);
    send_op(FUNC_ALLOC, '0);
    // above the depth, saturates
    write_pool_size('1);
    send_op(FUNC_ALLOC, '0);
    send_op(FUNC_FREE, INDEX_W'(1022));

    phase_slots = '{5, 8, 1024, 0, 2047, 1, 0, 0};
    phase_slots[6] = $urandom_range(2, 64);
    phase_slots[7] = $urandom_range(0, 2047);
    for (p = 0; p < PHASES; p++) begin
      write_pool_size(COUNT_W'(phase_slots[p]));
      alloc_pct = $urandom_range(45, 80);
      if (p % 3 == 1) begin
        tx_stall_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_stall_pct = $urandom_range(10, 50);
        rx_stall_pct = $urandom_range(10, 50);
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 20) begin
          hold_outputs = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
          send_op(FUNC_ALLOC, INDEX_W'($urandom));
        end else if (roll < 92 && held_slots.size() > 0) begin
          send_op(FUNC_FREE,
                  INDEX_W'(held_slots[$urandom_range(0, held_slots.size() - 1)]));
        end else if (alloc_count < POOL_DEPTH) begin
          // surely at or above the bump count, so rejected without harm
          send_op(FUNC_FREE, INDEX_W'($urandom_range(alloc_count, POOL_DEPTH - 1)));
        end else begin
          send_op(FUNC_ALLOC, INDEX_W'($urandom));
        end
      end
    end

    // double free last: it leaves a loop in the list that only reset clears
    drain_pool_ops();
    if (held_slots.size() > 0) begin
      victim = held_slots[0];
      send_op(FUNC_FREE, INDEX_W'(victim));
      send_op(FUNC_FREE, INDEX_W'(victim));
      send_op(FUNC_ALLOC, '0);
      send_op(FUNC_ALLOC, '0);
      send_op(FUNC_ALLOC, '0);
    end

    drain_pool_ops();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
